@@ src/hti_pkg.sv @@
// Shared types, constants and codes for the help topic indexer.
`default_nettype none

package hti_pkg;

  // Default name buffer length; names keep at most NAME_LEN_DEF-1 bytes
  localparam int NAME_LEN_DEF = 32;

  // Character codes used by the header parser
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Request operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Input request
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  // One result of a topic run
  typedef struct packed {
    logic [31:0] body_start;
    logic [31:0] body_length;
    logic [31:0] topic_number;
    logic [7:0]  name_char;
    logic        name_done;
  } topic_t;

  // Header line parser phase
  typedef enum logic [1:0] {
    PH_ORDINARY = 2'd0,
    PH_SKIP     = 2'd1,
    PH_NAME     = 2'd2,
    PH_REST     = 2'd3
  } phase_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_LOAD = 2'd2
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;    // input request accepted this cycle
    logic rd;      // read name buffer at drain index
    logic load;    // load output register
    logic inc;     // advance drain index
  } hti_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_req;  // current request closes an open topic
    logic last;      // drain index is at the terminator
    logic out_free;  // output register can take a result
  } hti_sts_t;

endpackage

`default_nettype wire

@@ src/hti_ctrl.sv @@
// Controller: accepts bytes and sequences the drain of a finished topic.
`default_nettype none

module hti_ctrl
  import hti_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_stall,
  input  wire hti_sts_t sts,
  output hti_cmd_t      cmd
);

  ctl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.take   = item_valid;
        if (item_valid && sts.emit_req) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.inc    = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/hti_dp.sv @@
// Datapath: position counters, header parser, name buffer and output register.
`default_nettype none

module hti_dp
  import hti_pkg::*;
#(
  parameter int NAME_LEN = NAME_LEN_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire item_t    item,
  input  wire hti_cmd_t cmd,
  output hti_sts_t      sts,
  output logic          topic_valid,
  input  wire logic     topic_stall,
  output topic_t        topic
);

  localparam int FW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
  localparam logic [FW-1:0] FILL_MAX = FW'(NAME_LEN - 1);

  // Parser and position state
  logic [31:0]   byte_offset, byte_offset_next;
  logic          line_begins, line_begins_next;
  phase_t        phase, phase_next;
  logic [FW-1:0] fill, fill_next;
  logic [31:0]   open_start, open_start_next;
  logic          topic_open, topic_open_next;
  logic [31:0]   topics_seen, topics_seen_next;
  logic [7:0]    last_char;

  // Snapshot of the topic being drained
  logic [31:0]   em_start, em_len, em_num;
  logic [FW-1:0] em_n, em_start_n;
  logic [31:0]   snap_start;
  logic [FW-1:0] k;

  // Name buffer
  logic [7:0]    mem [NAME_LEN];
  logic [7:0]    rdata;
  logic          wr;

  logic [7:0]    c;
  logic          is_end;
  logic          amp_open;

  assign c        = item.data_byte;
  assign is_end   = (item.op == OP_END);
  assign amp_open = line_begins && (c == CH_AMP);
  assign em_start_n = fill;

  // Status to the controller
  assign sts.emit_req = topic_open && (is_end || amp_open);
  assign sts.last     = (k == em_n);
  assign sts.out_free = !topic_valid || !topic_stall;

  // Body start as seen at end of input inside a header line
  assign snap_start = (is_end && (phase != PH_ORDINARY)) ? byte_offset : open_start;

  // Next parser state for one accepted request
  always_comb begin
    byte_offset_next = byte_offset;
    line_begins_next = line_begins;
    phase_next       = phase;
    fill_next        = fill;
    open_start_next  = open_start;
    topic_open_next  = topic_open;
    topics_seen_next = topics_seen;
    wr               = 1'b0;
    if (is_end) begin
      byte_offset_next = '0;
      line_begins_next = 1'b1;
      phase_next       = PH_ORDINARY;
      fill_next        = '0;
      open_start_next  = '0;
      topic_open_next  = 1'b0;
      topics_seen_next = '0;
    end else begin
      if (amp_open) begin
        topic_open_next = 1'b1;
        if (topics_seen != '1) begin
          topics_seen_next = topics_seen + 32'd1;
        end
        fill_next  = '0;
        phase_next = PH_SKIP;
      end else if ((phase == PH_SKIP) || (phase == PH_NAME)) begin
        if (phase == PH_SKIP) begin
          if (c == CH_NUL) begin
            phase_next = PH_REST;
          end else if (c != CH_LF && c != CH_SP && c != CH_TAB && c != CH_CR) begin
            phase_next = PH_NAME;
            wr         = 1'b1;
          end
        end else begin
          if (c == CH_CR || c == CH_NUL) begin
            phase_next = PH_REST;
          end else if (c != CH_LF) begin
            wr = 1'b1;
          end
        end
        // Capture: stop at the length cut, fold runs of spaces
        if (wr) begin
          if (fill >= FILL_MAX) begin
            phase_next = PH_REST;
            wr         = 1'b0;
          end else if (c == CH_SP && fill != '0 && last_char == CH_SP) begin
            wr = 1'b0;
          end else begin
            fill_next = fill + FW'(1);
          end
        end
      end
      if (byte_offset != '1) begin
        byte_offset_next = byte_offset + 32'd1;
      end
      if (c == CH_LF && phase_next != PH_ORDINARY) begin
        open_start_next = byte_offset_next;
        phase_next      = PH_ORDINARY;
      end
      line_begins_next = (c == CH_LF);
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      line_begins <= 1'b1;
      phase       <= PH_ORDINARY;
      fill        <= '0;
      open_start  <= '0;
      topic_open  <= 1'b0;
      topics_seen <= '0;
    end else if (cmd.take) begin
      byte_offset <= byte_offset_next;
      line_begins <= line_begins_next;
      phase       <= phase_next;
      fill        <= fill_next;
      open_start  <= open_start_next;
      topic_open  <= topic_open_next;
      topics_seen <= topics_seen_next;
    end
  end

  // Last stored name byte, for space folding
  always_ff @(posedge clk) begin
    if (cmd.take && wr) begin
      last_char <= c;
    end
  end

  // Snapshot of the closing topic and drain index
  always_ff @(posedge clk) begin
    if (rst) begin
      em_n <= '0;
      k    <= '0;
    end else if (cmd.take) begin
      em_n <= em_start_n;
      k    <= '0;
    end else if (cmd.inc) begin
      k <= k + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      em_start <= snap_start;
      em_len   <= byte_offset - snap_start;
      em_num   <= topics_seen;
    end
  end

  // Name buffer write and registered read
  always_ff @(posedge clk) begin
    if (cmd.take && wr) begin
      mem[fill] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[k];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      topic_valid <= 1'b0;
    end else if (cmd.load) begin
      topic_valid <= 1'b1;
    end else if (!topic_stall) begin
      topic_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      topic.body_start   <= em_start;
      topic.body_length  <= em_len;
      topic.topic_number <= em_num;
      topic.name_char    <= sts.last ? CH_NUL : rdata;
      topic.name_done    <= sts.last;
    end
  end

`ifndef ASSERT_OFF
  // Name never grows past the cut
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("name fill past limit");

  // Drain index stays within the snapshot name
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    k <= em_n)
    else $error("drain index past terminator");

  // A result is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!topic_valid || !topic_stall))
    else $error("output register overwritten");

  // A newline byte leaves the parser at a line start in ordinary phase
  a_lf_line: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && !is_end && c == CH_LF) |=> (line_begins && phase == PH_ORDINARY))
    else $error("newline not handled");
`endif

endmodule

`default_nettype wire

@@ src/help_topic_indexer.sv @@
// Help topic indexer: scans a help text byte stream and reports each topic.
//
// Usage:
//   item channel (item_valid / item_stall / item): one request per accepted
//   cycle, either a file byte (op = byte) or end of input (op = end), which
//   flushes the open topic and returns the block to its reset state.
//   topic channel (topic_valid / topic_stall / topic): for each closed topic a
//   run of results, one per stored name byte and then a terminator with
//   name_done set; every result carries body start, length and topic number.
// Throughput: one byte per cycle while no topic closes. A request that closes
//   a topic (the next topic's '&' or end of input) starts a drain of the name
//   buffer: each result is made by a buffer read and then an output register
//   load. The item side is stalled for the whole drain.
// Stalls: a stalled result holds in the output register; the drain waits.
// Reset (rst, synchronous): clears counters, parser and output valid; the
//   name buffer is not cleared and needs no clearing pass.
`default_nettype none

module help_topic_indexer
  import hti_pkg::*;
#(
  parameter int NAME_LEN = NAME_LEN_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   item_valid,
  output logic        item_stall,
  input  wire item_t  item,
  output logic        topic_valid,
  input  wire logic   topic_stall,
  output topic_t      topic
);

  hti_cmd_t cmd;
  hti_sts_t sts;

  hti_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  hti_dp #(
    .NAME_LEN (NAME_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .sts         (sts),
    .topic_valid (topic_valid),
    .topic_stall (topic_stall),
    .topic       (topic)
  );

endmodule

`default_nettype wire
